>>> sv/maze_wall_map_flood_fill_top_macros.svh
// Assertion macros used by the maze map checker
`ifndef MAZE_WALL_MAP_FLOOD_FILL_TOP_MACROS_SVH
`define MAZE_WALL_MAP_FLOOD_FILL_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MWFF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("maze map assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MWFF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("maze map assertion failed");

`endif

>>> sv/mwff_pkg.sv
// Shared types, constants and helpers for the maze wall map and flood fill block
package mwff_pkg;

	localparam int DIST_W  = 9;
	localparam int WALL_W  = 4;
	localparam int SENSE_W = 12;
	localparam int COORD_W = 4;
	localparam int SUM_W   = 14;

	localparam int MAZE_SIDE_DEF      = 16;
	localparam int FRONTIER_DEPTH_DEF = 256;

	localparam logic [DIST_W-1:0]  UNREACHED  = 9'd257;
	localparam logic [DIST_W-1:0]  MAX_LEVEL  = 9'd256;
	localparam logic [SENSE_W-1:0] THR_RESET  = 12'd2048;

	// Directions
	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	// Action codes
	localparam logic ACT_SENSE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_WRD,
		ST_WWR,
		ST_DCLR,
		ST_SEED,
		ST_FRD,
		ST_FWAIT,
		ST_WREAD,
		ST_WCAP,
		ST_NRD,
		ST_NCHK,
		ST_LVL,
		ST_RRD,
		ST_RCAP,
		ST_HOLD
	} seq_state_t;

	typedef struct packed {
		logic wall_we;
		logic dist_we;
		logic fr_we;
	} mem_ctl_t;

	// Wall bit for one side of a cell
	function automatic logic [WALL_W-1:0] side_bit(input logic [1:0] d);
		logic [WALL_W-1:0] b;
		case (d)
			DIR_N: b = 4'b0100;
			DIR_E: b = 4'b0001;
			DIR_S: b = 4'b1000;
			DIR_W: b = 4'b0010;
			default: b = 4'b0000;
		endcase
		return b;
	endfunction

endpackage

>>> sv/mwff_store.sv
// Wall map, distance map and ping-pong frontier memories
module mwff_store #(
	parameter int MAZE_SIDE      = mwff_pkg::MAZE_SIDE_DEF,
	parameter int FRONTIER_DEPTH = mwff_pkg::FRONTIER_DEPTH_DEF
) (
	input  logic                                clk,
	input  mwff_pkg::mem_ctl_t                  ctl,
	input  logic [$clog2(MAZE_SIDE*MAZE_SIDE)-1:0] wall_waddr,
	input  logic [mwff_pkg::WALL_W-1:0]         wall_wdata,
	input  logic [$clog2(MAZE_SIDE*MAZE_SIDE)-1:0] wall_raddr,
	output logic [mwff_pkg::WALL_W-1:0]         wall_rdata,
	input  logic [$clog2(MAZE_SIDE*MAZE_SIDE)-1:0] dist_waddr,
	input  logic [mwff_pkg::DIST_W-1:0]         dist_wdata,
	input  logic [$clog2(MAZE_SIDE*MAZE_SIDE)-1:0] dist_raddr,
	output logic [mwff_pkg::DIST_W-1:0]         dist_rdata,
	input  logic [$clog2(FRONTIER_DEPTH):0]     fr_waddr,
	input  logic [2*$clog2(MAZE_SIDE)-1:0]      fr_wdata,
	input  logic [$clog2(FRONTIER_DEPTH):0]     fr_raddr,
	output logic [2*$clog2(MAZE_SIDE)-1:0]      fr_rdata
);

	localparam int CELLS = MAZE_SIDE * MAZE_SIDE;
	localparam int FEW   = 2 * $clog2(MAZE_SIDE);
	localparam int FENT  = 2 ** ($clog2(FRONTIER_DEPTH) + 1);

	logic [mwff_pkg::WALL_W-1:0] wall_mem [CELLS];
	logic [mwff_pkg::DIST_W-1:0] dist_mem [CELLS];
	logic [FEW-1:0]              fr_mem   [FENT];

	// Wall map port
	always_ff @(posedge clk) begin
		if (ctl.wall_we) begin
			wall_mem[wall_waddr] <= wall_wdata;
		end
		wall_rdata <= wall_mem[wall_raddr];
	end

	// Distance map port
	always_ff @(posedge clk) begin
		if (ctl.dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
		dist_rdata <= dist_mem[dist_raddr];
	end

	// Frontier port, bank bit on top of the address
	always_ff @(posedge clk) begin
		if (ctl.fr_we) begin
			fr_mem[fr_waddr] <= fr_wdata;
		end
		fr_rdata <= fr_mem[fr_raddr];
	end

endmodule

>>> sv/mwff_seq.sv
// Sequencer and datapath: map clear, wall marking, distance clear, seeding, level-by-level flood and cell reads
module mwff_seq #(
	parameter int MAZE_SIDE      = mwff_pkg::MAZE_SIDE_DEF,
	parameter int FRONTIER_DEPTH = mwff_pkg::FRONTIER_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [mwff_pkg::SENSE_W-1:0]        thr,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                action,
	input  logic [mwff_pkg::COORD_W-1:0]        cell_x,
	input  logic [mwff_pkg::COORD_W-1:0]        cell_y,
	input  logic [1:0]                          heading,
	input  logic [mwff_pkg::SENSE_W-1:0]        sense_left,
	input  logic [mwff_pkg::SENSE_W-1:0]        sense_front_a,
	input  logic [mwff_pkg::SENSE_W-1:0]        sense_front_b,
	input  logic [mwff_pkg::SENSE_W-1:0]        sense_front_c,
	input  logic [mwff_pkg::SENSE_W-1:0]        sense_right,
	input  logic [mwff_pkg::COORD_W-1:0]        goal_x,
	input  logic [mwff_pkg::COORD_W-1:0]        goal_y,
	input  logic                                single_goal,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [mwff_pkg::DIST_W-1:0]         res_dist,
	output logic [mwff_pkg::WALL_W-1:0]         res_walls,
	output mwff_pkg::mem_ctl_t                  ctl,
	output logic [$clog2(MAZE_SIDE*MAZE_SIDE)-1:0] wall_waddr,
	output logic [mwff_pkg::WALL_W-1:0]         wall_wdata,
	output logic [$clog2(MAZE_SIDE*MAZE_SIDE)-1:0] wall_raddr,
	input  logic [mwff_pkg::WALL_W-1:0]         wall_rdata,
	output logic [$clog2(MAZE_SIDE*MAZE_SIDE)-1:0] dist_waddr,
	output logic [mwff_pkg::DIST_W-1:0]         dist_wdata,
	output logic [$clog2(MAZE_SIDE*MAZE_SIDE)-1:0] dist_raddr,
	input  logic [mwff_pkg::DIST_W-1:0]         dist_rdata,
	output logic [$clog2(FRONTIER_DEPTH):0]     fr_waddr,
	output logic [2*$clog2(MAZE_SIDE)-1:0]      fr_wdata,
	output logic [$clog2(FRONTIER_DEPTH):0]     fr_raddr,
	input  logic [2*$clog2(MAZE_SIDE)-1:0]      fr_rdata
);

	localparam int RW    = $clog2(MAZE_SIDE);
	localparam int CELLS = MAZE_SIDE * MAZE_SIDE;
	localparam int CW    = $clog2(CELLS);
	localparam int FIW   = $clog2(FRONTIER_DEPTH);
	localparam int FCW   = $clog2(FRONTIER_DEPTH + 1);
	localparam logic [RW-1:0]  LAST_RC  = RW'(MAZE_SIDE - 1);
	localparam logic [RW-1:0]  CTR_LO   = RW'(MAZE_SIDE / 2 - 1);
	localparam logic [CW-1:0]  LAST_CELL = CW'(CELLS - 1);
	localparam logic [FCW-1:0] FR_FULL  = FCW'(FRONTIER_DEPTH);
	localparam logic [2:0]     LAST_OP  = 3'd5;

	mwff_pkg::seq_state_t state_q, state_d;

	logic [RW-1:0]  r_q, c_q, gr_q, gc_q, pr_q, pc_q;
	logic [1:0]     h_q, sidx_q, d_q;
	logic           in_q, single_q, goal_in_q, bank_q;
	logic [2:0]     mark_q, op_q;
	logic [CW-1:0]  cnt_q;
	logic [FCW-1:0] cur_cnt_q, nxt_cnt_q, i_q;
	logic [mwff_pkg::DIST_W-1:0] level_q, nd;
	logic [mwff_pkg::WALL_W-1:0] pw_q;

	logic [1:0]     op_d;
	logic           op_nb, op_mark, op_ok, seed_ok, seed_last, nb_blk, unreached;
	logic [RW-1:0]  op_r, op_c, seed_r, seed_c, nb_r, nb_c;
	logic [mwff_pkg::WALL_W-1:0] op_bit;
	logic           acc_in;
	logic [mwff_pkg::SUM_W-1:0] front_sum, thr3;

	function automatic logic [CW-1:0] cell_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
		return CW'(CW'(r) * CW'(MAZE_SIDE) + CW'(c));
	endfunction

	function automatic logic [RW-1:0] step_r(input logic [RW-1:0] r, input logic [1:0] d);
		logic [RW-1:0] n;
		case (d)
			mwff_pkg::DIR_N: n = r - RW'(1);
			mwff_pkg::DIR_S: n = r + RW'(1);
			default:         n = r;
		endcase
		return n;
	endfunction

	function automatic logic [RW-1:0] step_c(input logic [RW-1:0] c, input logic [1:0] d);
		logic [RW-1:0] n;
		case (d)
			mwff_pkg::DIR_E: n = c + RW'(1);
			mwff_pkg::DIR_W: n = c - RW'(1);
			default:         n = c;
		endcase
		return n;
	endfunction

	function automatic logic nb_ok(input logic [RW-1:0] r, input logic [RW-1:0] c,
			input logic [1:0] d);
		logic ok;
		case (d)
			mwff_pkg::DIR_N: ok = (r != '0);
			mwff_pkg::DIR_E: ok = (c != LAST_RC);
			mwff_pkg::DIR_S: ok = (r != LAST_RC);
			default:         ok = (c != '0);
		endcase
		return ok;
	endfunction

	// Wall-marking operation decode: side in op_q[2:1], own cell or neighbor in op_q[0]
	always_comb begin
		case (op_q[2:1])
			2'd0: begin
				op_d    = h_q + 2'd3;
				op_mark = mark_q[0];
			end
			2'd1: begin
				op_d    = h_q + 2'd1;
				op_mark = mark_q[1];
			end
			2'd2: begin
				op_d    = h_q;
				op_mark = mark_q[2];
			end
			default: begin
				op_d    = h_q;
				op_mark = 1'b0;
			end
		endcase
		op_nb  = op_q[0];
		op_ok  = op_mark && (!op_nb || nb_ok(r_q, c_q, op_d));
		op_r   = op_nb ? step_r(r_q, op_d) : r_q;
		op_c   = op_nb ? step_c(c_q, op_d) : c_q;
		op_bit = mwff_pkg::side_bit(op_nb ? op_d + 2'd2 : op_d);
	end

	// Seed cell: goal or one of the four center cells
	always_comb begin
		seed_r    = single_q ? gr_q : CTR_LO + RW'(sidx_q[1]);
		seed_c    = single_q ? gc_q : CTR_LO + RW'(sidx_q[0]);
		seed_ok   = single_q ? goal_in_q : 1'b1;
		seed_last = single_q || (sidx_q == 2'd3);
	end

	// Neighbor under test during the flood
	always_comb begin
		nb_r      = step_r(pr_q, d_q);
		nb_c      = step_c(pc_q, d_q);
		nb_blk    = ((pw_q & mwff_pkg::side_bit(d_q)) != '0) || !nb_ok(pr_q, pc_q, d_q);
		unreached = (dist_rdata == mwff_pkg::UNREACHED);
		nd        = (level_q == mwff_pkg::MAX_LEVEL) ? mwff_pkg::MAX_LEVEL
			: level_q + mwff_pkg::DIST_W'(1);
	end

	// Sensor tests at the input: floor(sum/3) < thr is sum < 3*thr
	always_comb begin
		acc_in    = (32'(cell_x) < MAZE_SIDE) && (32'(cell_y) < MAZE_SIDE);
		front_sum = mwff_pkg::SUM_W'(sense_front_a) + mwff_pkg::SUM_W'(sense_front_b)
			+ mwff_pkg::SUM_W'(sense_front_c);
		thr3      = {1'b0, thr, 1'b0} + mwff_pkg::SUM_W'(thr);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mwff_pkg::ST_CLR:   if (cnt_q == LAST_CELL) state_d = mwff_pkg::ST_IDLE;
			mwff_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (action == mwff_pkg::ACT_READ) ? mwff_pkg::ST_RRD
						: mwff_pkg::ST_WRD;
				end
			end
			mwff_pkg::ST_WRD: begin
				if (op_ok) state_d = mwff_pkg::ST_WWR;
				else if (op_q == LAST_OP) state_d = mwff_pkg::ST_DCLR;
			end
			mwff_pkg::ST_WWR: begin
				state_d = (op_q == LAST_OP) ? mwff_pkg::ST_DCLR : mwff_pkg::ST_WRD;
			end
			mwff_pkg::ST_DCLR:  if (cnt_q == LAST_CELL) state_d = mwff_pkg::ST_SEED;
			mwff_pkg::ST_SEED:  if (seed_last) state_d = mwff_pkg::ST_FRD;
			mwff_pkg::ST_FRD: begin
				state_d = (i_q == cur_cnt_q) ? mwff_pkg::ST_LVL : mwff_pkg::ST_FWAIT;
			end
			mwff_pkg::ST_FWAIT: state_d = mwff_pkg::ST_WREAD;
			mwff_pkg::ST_WREAD: state_d = mwff_pkg::ST_WCAP;
			mwff_pkg::ST_WCAP:  state_d = mwff_pkg::ST_NRD;
			mwff_pkg::ST_NRD: begin
				if (!nb_blk) state_d = mwff_pkg::ST_NCHK;
				else if (d_q == 2'd3) state_d = mwff_pkg::ST_FRD;
			end
			mwff_pkg::ST_NCHK: begin
				state_d = (d_q == 2'd3) ? mwff_pkg::ST_FRD : mwff_pkg::ST_NRD;
			end
			mwff_pkg::ST_LVL: begin
				state_d = (nxt_cnt_q == '0) ? mwff_pkg::ST_RRD : mwff_pkg::ST_FRD;
			end
			mwff_pkg::ST_RRD:   state_d = mwff_pkg::ST_RCAP;
			mwff_pkg::ST_RCAP:  state_d = mwff_pkg::ST_HOLD;
			mwff_pkg::ST_HOLD:  if (res_ready) state_d = mwff_pkg::ST_IDLE;
			default:            state_d = mwff_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and handshake outputs
	always_comb begin
		ctl.wall_we = (state_q == mwff_pkg::ST_CLR) || (state_q == mwff_pkg::ST_WWR);
		ctl.dist_we = (state_q == mwff_pkg::ST_CLR) || (state_q == mwff_pkg::ST_DCLR)
			|| ((state_q == mwff_pkg::ST_SEED) && seed_ok)
			|| ((state_q == mwff_pkg::ST_NCHK) && unreached);
		ctl.fr_we   = ((state_q == mwff_pkg::ST_SEED) && seed_ok)
			|| ((state_q == mwff_pkg::ST_NCHK) && unreached && (nxt_cnt_q < FR_FULL));

		wall_waddr = (state_q == mwff_pkg::ST_CLR) ? cnt_q : cell_addr(op_r, op_c);
		wall_wdata = (state_q == mwff_pkg::ST_CLR) ? '0 : (wall_rdata | op_bit);
		case (state_q)
			mwff_pkg::ST_WRD: wall_raddr = cell_addr(op_r, op_c);
			mwff_pkg::ST_RRD: wall_raddr = cell_addr(r_q, c_q);
			default:          wall_raddr = cell_addr(pr_q, pc_q);
		endcase

		case (state_q)
			mwff_pkg::ST_SEED: begin
				dist_waddr = cell_addr(seed_r, seed_c);
				dist_wdata = '0;
			end
			mwff_pkg::ST_NCHK: begin
				dist_waddr = cell_addr(nb_r, nb_c);
				dist_wdata = nd;
			end
			default: begin
				dist_waddr = cnt_q;
				dist_wdata = mwff_pkg::UNREACHED;
			end
		endcase
		dist_raddr = (state_q == mwff_pkg::ST_RRD) ? cell_addr(r_q, c_q) : cell_addr(nb_r, nb_c);

		if (state_q == mwff_pkg::ST_SEED) begin
			fr_waddr = {bank_q, cur_cnt_q[FIW-1:0]};
			fr_wdata = {seed_r, seed_c};
		end else begin
			fr_waddr = {~bank_q, nxt_cnt_q[FIW-1:0]};
			fr_wdata = {nb_r, nb_c};
		end
		fr_raddr = {bank_q, i_q[FIW-1:0]};

		in_ready  = (state_q == mwff_pkg::ST_IDLE);
		res_valid = (state_q == mwff_pkg::ST_HOLD);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mwff_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Counters and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			op_q      <= '0;
			sidx_q    <= '0;
			bank_q    <= 1'b0;
			cur_cnt_q <= '0;
			nxt_cnt_q <= '0;
			i_q       <= '0;
			d_q       <= '0;
			level_q   <= '0;
			mark_q    <= '0;
			in_q      <= 1'b0;
			single_q  <= 1'b0;
			goal_in_q <= 1'b0;
		end else begin
			case (state_q)
				mwff_pkg::ST_CLR: cnt_q <= cnt_q + CW'(1);
				mwff_pkg::ST_IDLE: begin
					if (in_valid) begin
						cnt_q     <= '0;
						op_q      <= '0;
						in_q      <= acc_in;
						single_q  <= single_goal;
						goal_in_q <= (32'(goal_x) < MAZE_SIDE) && (32'(goal_y) < MAZE_SIDE);
						if (action == mwff_pkg::ACT_SENSE && acc_in) begin
							mark_q <= {front_sum < thr3, sense_right < thr, sense_left < thr};
						end else begin
							mark_q <= '0;
						end
					end
				end
				mwff_pkg::ST_WRD:  if (!op_ok) op_q <= op_q + 3'd1;
				mwff_pkg::ST_WWR:  op_q <= op_q + 3'd1;
				mwff_pkg::ST_DCLR: begin
					cnt_q     <= cnt_q + CW'(1);
					sidx_q    <= '0;
					bank_q    <= 1'b0;
					cur_cnt_q <= '0;
				end
				mwff_pkg::ST_SEED: begin
					if (seed_ok) cur_cnt_q <= cur_cnt_q + FCW'(1);
					sidx_q    <= sidx_q + 2'd1;
					i_q       <= '0;
					nxt_cnt_q <= '0;
					level_q   <= '0;
				end
				mwff_pkg::ST_FRD:  if (i_q != cur_cnt_q) i_q <= i_q + FCW'(1);
				mwff_pkg::ST_WCAP: d_q <= '0;
				mwff_pkg::ST_NRD:  if (nb_blk) d_q <= d_q + 2'd1;
				mwff_pkg::ST_NCHK: begin
					if (unreached && (nxt_cnt_q < FR_FULL)) nxt_cnt_q <= nxt_cnt_q + FCW'(1);
					d_q <= d_q + 2'd1;
				end
				mwff_pkg::ST_LVL: begin
					cur_cnt_q <= nxt_cnt_q;
					nxt_cnt_q <= '0;
					bank_q    <= ~bank_q;
					i_q       <= '0;
					level_q   <= nd;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == mwff_pkg::ST_IDLE && in_valid) begin
			r_q  <= RW'(cell_x);
			c_q  <= RW'(cell_y);
			h_q  <= heading;
			gr_q <= RW'(goal_x);
			gc_q <= RW'(goal_y);
		end
		if (state_q == mwff_pkg::ST_FWAIT) begin
			pr_q <= fr_rdata[2*RW-1:RW];
			pc_q <= fr_rdata[RW-1:0];
		end
		if (state_q == mwff_pkg::ST_WCAP) begin
			pw_q <= wall_rdata;
		end
		if (state_q == mwff_pkg::ST_RCAP) begin
			res_dist  <= in_q ? dist_rdata : mwff_pkg::UNREACHED;
			res_walls <= in_q ? wall_rdata : '0;
		end
	end

endmodule

>>> sv/maze_wall_map_flood_fill_top.sv
// Maze wall map and flood fill: a read item goes through the read, capture and hold states
// before its result moves to the output register. A sense item marks walls, clears the
// distance map, seeds the goal cells and floods level by level, all through the one
// shared sequencer and map ports.
// One item at a time; the next transfer is taken once the result sits in the output register.
// After reset the maps are cleared one cell a cycle with ready low.
module maze_wall_map_flood_fill_top #(
	parameter int MAZE_SIDE      = mwff_pkg::MAZE_SIDE_DEF,
	parameter int FRONTIER_DEPTH = mwff_pkg::FRONTIER_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mwff_pkg::SENSE_W-1:0] cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [mwff_pkg::COORD_W-1:0] cell_x,
	input  logic [mwff_pkg::COORD_W-1:0] cell_y,
	input  logic [1:0]                   heading,
	input  logic [mwff_pkg::SENSE_W-1:0] sense_left,
	input  logic [mwff_pkg::SENSE_W-1:0] sense_front_a,
	input  logic [mwff_pkg::SENSE_W-1:0] sense_front_b,
	input  logic [mwff_pkg::SENSE_W-1:0] sense_front_c,
	input  logic [mwff_pkg::SENSE_W-1:0] sense_right,
	input  logic [mwff_pkg::COORD_W-1:0] goal_x,
	input  logic [mwff_pkg::COORD_W-1:0] goal_y,
	input  logic                         single_goal,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mwff_pkg::DIST_W-1:0]  distance,
	output logic [mwff_pkg::WALL_W-1:0]  walls
);

	localparam int CW  = $clog2(MAZE_SIDE * MAZE_SIDE);
	localparam int FAW = $clog2(FRONTIER_DEPTH) + 1;
	localparam int FEW = 2 * $clog2(MAZE_SIDE);

	logic [mwff_pkg::SENSE_W-1:0] thr_q;
	logic                         out_valid_q, res_valid, res_ready;
	logic [mwff_pkg::DIST_W-1:0]  res_dist, dist_q;
	logic [mwff_pkg::WALL_W-1:0]  res_walls, walls_q;
	mwff_pkg::mem_ctl_t           ctl;
	logic [CW-1:0]                wall_waddr, wall_raddr, dist_waddr, dist_raddr;
	logic [mwff_pkg::WALL_W-1:0]  wall_wdata, wall_rdata;
	logic [mwff_pkg::DIST_W-1:0]  dist_wdata, dist_rdata;
	logic [FAW-1:0]               fr_waddr, fr_raddr;
	logic [FEW-1:0]               fr_wdata, fr_rdata;

	// Hold the wall threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mwff_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	mwff_seq #(
		.MAZE_SIDE      (MAZE_SIDE),
		.FRONTIER_DEPTH (FRONTIER_DEPTH)
	) u_seq (
		.clk, .arst_n,
		.thr            (thr_q),
		.in_valid, .in_ready,
		.action, .cell_x, .cell_y, .heading,
		.sense_left, .sense_front_a, .sense_front_b, .sense_front_c, .sense_right,
		.goal_x, .goal_y, .single_goal,
		.res_valid, .res_ready, .res_dist, .res_walls,
		.ctl,
		.wall_waddr, .wall_wdata, .wall_raddr, .wall_rdata,
		.dist_waddr, .dist_wdata, .dist_raddr, .dist_rdata,
		.fr_waddr, .fr_wdata, .fr_raddr, .fr_rdata
	);

	mwff_store #(
		.MAZE_SIDE      (MAZE_SIDE),
		.FRONTIER_DEPTH (FRONTIER_DEPTH)
	) u_store (
		.clk,
		.ctl,
		.wall_waddr, .wall_wdata, .wall_raddr, .wall_rdata,
		.dist_waddr, .dist_wdata, .dist_raddr, .dist_rdata,
		.fr_waddr, .fr_wdata, .fr_raddr, .fr_rdata
	);

	// Output register: load a finished result when the slot is free
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			dist_q  <= res_dist;
			walls_q <= res_walls;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = dist_q;
	assign walls     = walls_q;

endmodule

>>> sv/mwff_chk.sv
// Port checker for the maze map block and its bind
`include "maze_wall_map_flood_fill_top_macros.svh"

module mwff_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mwff_pkg::DIST_W-1:0] distance
);

	// A pending result stays until transferred
	`MWFF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// The block is busy in the cycle after an input transfer
	`MWFF_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)

	// A result never appears right after an input transfer
	`MWFF_ASSERT_IMP(a_no_instant_res, clk, arst_n, $rose(out_valid),
		!$past(in_valid && in_ready))

	// Distances stay within the unreached code
	`MWFF_ASSERT_IMP(a_dist_range, clk, arst_n, out_valid, distance <= mwff_pkg::UNREACHED)

endmodule

bind maze_wall_map_flood_fill_top mwff_chk u_mwff_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.distance  (distance)
);

>>> sim/testbench.sv
// Testbench for the maze wall map and flood fill block: scoreboard with BFS predictor
`timescale 1ns / 100ps

module testbench;

	typedef struct {
		logic        act;
		logic [3:0]  row;
		logic [3:0]  col;
		logic [1:0]  hdg;
		logic [11:0] rd_left;
		logic [11:0] rd_fa;
		logic [11:0] rd_fb;
		logic [11:0] rd_fc;
		logic [11:0] rd_right;
		logic [3:0]  goal_row;
		logic [3:0]  goal_col;
		logic        one_goal;
	} maze_item_t;

	// Predicts the block's maps and checks each returned cell
	class maze_scoreboard;
		logic [3:0]  wall_grid[256];
		logic [8:0]  dist_grid[256];
		logic [11:0] threshold;
		logic [8:0]  pending_dist[$];
		logic [3:0]  pending_walls[$];
		int          errors;

		function new();
			foreach (wall_grid[i]) wall_grid[i] = '0;
			foreach (dist_grid[i]) dist_grid[i] = mwff_pkg::UNREACHED;
			threshold = mwff_pkg::THR_RESET;
			errors = 0;
		endfunction

		function logic [3:0] wall_of(logic [1:0] d);
			case (d)
				mwff_pkg::DIR_N: return 4'b0100;
				mwff_pkg::DIR_E: return 4'b0001;
				mwff_pkg::DIR_S: return 4'b1000;
				default: return 4'b0010;
			endcase
		endfunction

		function bit step(int r, int c, logic [1:0] d, output int nr, output int nc);
			nr = r + ((d == mwff_pkg::DIR_N) ? -1 : (d == mwff_pkg::DIR_S) ? 1 : 0);
			nc = c + ((d == mwff_pkg::DIR_W) ? -1 : (d == mwff_pkg::DIR_E) ? 1 : 0);
			return nr >= 0 && nr < 16 && nc >= 0 && nc < 16;
		endfunction

		function void mark_wall(int r, int c, logic [1:0] d);
			int nr, nc;
			wall_grid[r*16+c] |= wall_of(d);
			if (step(r, c, d, nr, nc))
				wall_grid[nr*16+nc] |= wall_of(d + 2'd2);
		endfunction

		function void seed_cell(int r, int c, ref int q[$]);
			if (dist_grid[r*16+c] != mwff_pkg::UNREACHED) return;
			dist_grid[r*16+c] = '0;
			q.push_back(r*16+c);
		endfunction

		// Breadth-first flood from the goal set
		function void flood(bit one, int gr, int gc);
			int q[$];
			int k, nr, nc;
			foreach (dist_grid[i]) dist_grid[i] = mwff_pkg::UNREACHED;
			if (one) seed_cell(gr, gc, q);
			else begin
				seed_cell(7, 7, q);
				seed_cell(7, 8, q);
				seed_cell(8, 7, q);
				seed_cell(8, 8, q);
			end
			while (q.size() > 0) begin
				k = q.pop_front();
				for (int d = 0; d < 4; d++) begin
					if ((wall_grid[k] & wall_of(2'(d))) != 0) continue;
					if (!step(k / 16, k % 16, 2'(d), nr, nc)) continue;
					if (dist_grid[nr*16+nc] != mwff_pkg::UNREACHED) continue;
					dist_grid[nr*16+nc] = 9'(dist_grid[k] + 9'd1);
					q.push_back(nr*16+nc);
				end
			end
		endfunction

		function void note_input(maze_item_t it);
			int r, c;
			r = int'(it.row);
			c = int'(it.col);
			if (it.act == mwff_pkg::ACT_SENSE) begin
				if (it.rd_left < threshold) mark_wall(r, c, it.hdg + 2'd3);
				if (it.rd_right < threshold) mark_wall(r, c, it.hdg + 2'd1);
				if ((14'(it.rd_fa) + it.rd_fb + it.rd_fc) / 3 < threshold)
					mark_wall(r, c, it.hdg);
				flood(it.one_goal, int'(it.goal_row), int'(it.goal_col));
			end
			pending_dist.push_back(dist_grid[r*16+c]);
			pending_walls.push_back(wall_grid[r*16+c]);
		endfunction

		function void check_result(logic [8:0] d, logic [3:0] w);
			logic [8:0] ed;
			logic [3:0] ew;
			if (pending_dist.size() == 0) begin
				$display("%0t: unexpected result distance=%0d walls=%h", $time, d, w);
				errors++;
				return;
			end
			ed = pending_dist.pop_front();
			ew = pending_walls.pop_front();
			if (d !== ed) begin
				$display("%0t: distance expected %0d actual %0d", $time, ed, d);
				errors++;
			end
			if (w !== ew) begin
				$display("%0t: walls expected %h actual %h", $time, ew, w);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [11:0] cfg_wdata;
	maze_item_t  cur;
	logic [8:0]  distance;
	logic [3:0]  walls;

	maze_scoreboard sb;
	int send_idle_pct, recv_stall_pct, hold_request;

	maze_wall_map_flood_fill_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (cur.act),
		.cell_x       (cur.row),
		.cell_y       (cur.col),
		.heading      (cur.hdg),
		.sense_left   (cur.rd_left),
		.sense_front_a(cur.rd_fa),
		.sense_front_b(cur.rd_fb),
		.sense_front_c(cur.rd_fc),
		.sense_right  (cur.rd_right),
		.goal_x       (cur.goal_row),
		.goal_y       (cur.goal_col),
		.single_goal  (cur.one_goal),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.distance     (distance),
		.walls        (walls)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Limit the run
	initial begin
		#400ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Accept results, stall at random, honor long hold-off requests
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_result(distance, walls);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one item, hold it until transfer
	task automatic send_item(maze_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cur <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
	endtask

	// Drain all expected results, then write the threshold
	task automatic write_threshold(logic [11:0] v);
		in_valid <= 1'b0;
		wait_drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = v;
	endtask

	task automatic wait_drain();
		while (sb.pending_dist.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [11:0] reading(logic [11:0] thr);
		int lo, hi;
		// Keep readings close to the threshold so walls come and go
		if ($urandom_range(3) == 0) return 12'($urandom_range(4095));
		lo = (thr > 300) ? thr - 300 : 0;
		hi = (thr < 3795) ? thr + 300 : 4095;
		return 12'($urandom_range(hi, lo));
	endfunction

	function automatic maze_item_t rand_item(logic [11:0] thr);
		maze_item_t it;
		it.act      = ($urandom_range(99) < 40) ? mwff_pkg::ACT_SENSE : mwff_pkg::ACT_READ;
		it.row      = 4'($urandom_range(15));
		it.col      = 4'($urandom_range(15));
		it.hdg      = 2'($urandom_range(3));
		it.rd_left  = reading(thr);
		it.rd_fa    = reading(thr);
		it.rd_fb    = reading(thr);
		it.rd_fc    = reading(thr);
		it.rd_right = reading(thr);
		it.goal_row = 4'($urandom_range(15));
		it.goal_col = 4'($urandom_range(15));
		it.one_goal = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic maze_item_t make_item(logic a, int r, int c, int h, int l, int fa,
			int fb, int fc, int rt, int gr, int gc, logic one);
		maze_item_t it;
		it = '{a, 4'(r), 4'(c), 2'(h), 12'(l), 12'(fa), 12'(fb), 12'(fc), 12'(rt),
			4'(gr), 4'(gc), one};
		return it;
	endfunction

	task automatic random_phase(int n, int s_pct, int r_pct);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		repeat (n) send_item(rand_item(sb.threshold));
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		cur = make_item(mwff_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, corners, front average on both sides of the threshold
		send_item(make_item(mwff_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_item(make_item(mwff_pkg::ACT_SENSE, 0, 0, mwff_pkg::DIR_N, 0, 0, 0, 0, 0,
			0, 0, 1'b0));
		send_item(make_item(mwff_pkg::ACT_SENSE, 15, 15, mwff_pkg::DIR_E, 4095, 4095, 4095,
			4095, 4095, 15, 15, 1'b1));
		send_item(make_item(mwff_pkg::ACT_SENSE, 5, 6, mwff_pkg::DIR_S, 4095, 2047, 2048,
			2050, 4095, 0, 0, 1'b1));
		send_item(make_item(mwff_pkg::ACT_SENSE, 5, 6, mwff_pkg::DIR_W, 4095, 2047, 2047,
			2049, 4095, 0, 15, 1'b1));
		send_item(make_item(mwff_pkg::ACT_SENSE, 7, 7, mwff_pkg::DIR_N, 2047, 4095, 4095,
			4095, 2048, 15, 0, 1'b0));
		send_item(make_item(mwff_pkg::ACT_SENSE, 8, 8, mwff_pkg::DIR_E, 0, 4095, 4095, 4095,
			0, 0, 0, 1'b0));
		send_item(make_item(mwff_pkg::ACT_READ, 15, 0, mwff_pkg::DIR_W, 4095, 4095, 4095,
			4095, 4095, 15, 15, 1'b1));
		send_item(make_item(mwff_pkg::ACT_READ, 5, 6, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
		send_item(make_item(mwff_pkg::ACT_READ, 7, 8, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));

		random_phase(100, 0, 0);
		write_threshold(12'd0);
		random_phase(40, 81, 0);
		write_threshold(12'd4095);
		random_phase(60, 0, 81);

		// Hold the receiver off while items keep coming
		hold_request = 3000;
		random_phase(20, 0, 0);
		// Pause the sender until everything has returned
		in_valid <= 1'b0;
		wait_drain();

		write_threshold(12'($urandom_range(4095)));
		random_phase(100, 21, 21);
		write_threshold(12'd2048);
		random_phase(90, 0, 0);
		random_phase(80, 81, 81);

		in_valid <= 1'b0;
		wait_drain();
		if (sb.errors == 0 && sb.pending_dist.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
